[rtl/rbrh_pkg.sv]
// Shared types and constants for the repeated byte run histogram.
// No dependencies; all other files refer to it by scoped names.
`default_nettype none

package rbrh_pkg;

    localparam int HIST_BINS_DEF = 256;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 40;
    localparam int FILE_W  = 16;
    localparam int COUNT_W = 40;
    localparam int TOTAL_W = 48;
    localparam int LEN_W   = 32;
    localparam int CFG_IDX_W = 1;

    // shortest run that counts
    localparam logic [LEN_W-1:0] MIN_RUN = LEN_W'(2);

    // operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_ANY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_BYTE = CFG_IDX_W'(1);

    typedef struct packed {
        logic [TOTAL_W-1:0] total_bytes;
        logic [LEN_W-1:0]   best_length;
        logic [POS_W-1:0]   best_start;
        logic [FILE_W-1:0]  best_file;
        logic               best_valid;
    } totals_t;

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        totals_t            tot;
    } result_t;

    // request into the histogram memory pipeline
    typedef struct packed {
        logic inc;   // bump one bin
        logic rd;    // read one bin for a result
    } hist_req_t;

endpackage : rbrh_pkg

`default_nettype wire

[rtl/repeated_byte_run_histogram.sv]
// Top level of the repeated byte run histogram.
// Depends on rbrh_pkg, rbrh_run_tracker, rbrh_hist_mem and rbrh_out_buf.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------------
//   input    | s_valid / s_ready       | op, data_byte, segment_end, position,
//            |                         | file_number, bin_select
//   result   | m_valid / m_ready       | bin_count, totals, longest run record
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One input beat per cycle while s_ready is high, payload bytes and reads
// alike. A read result is registered in the bin memory stage, then in the
// output register or the skid behind it. After reset a clearing pass zeroes
// every bin with s_ready low; configuration writes are taken throughout. Any
// beat, byte or read, is held while the memory stage, output register and
// skid already carry two results and none leaves in that cycle.
`default_nettype none

module repeated_byte_run_histogram #(
    parameter int HIST_BINS = rbrh_pkg::HIST_BINS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_op,
    input  wire logic [rbrh_pkg::BYTE_W-1:0]    s_data_byte,
    input  wire logic                           s_segment_end,
    input  wire logic [rbrh_pkg::POS_W-1:0]     s_byte_position,
    input  wire logic [rbrh_pkg::FILE_W-1:0]    s_file_number,
    input  wire logic [rbrh_pkg::BYTE_W-1:0]    s_bin_select,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [rbrh_pkg::COUNT_W-1:0]        m_bin_count,
    output logic [rbrh_pkg::TOTAL_W-1:0]        m_total_bytes,
    output logic [rbrh_pkg::LEN_W-1:0]          m_longest_length,
    output logic [rbrh_pkg::POS_W-1:0]          m_longest_start,
    output logic [rbrh_pkg::FILE_W-1:0]         m_longest_file,
    output logic                                m_found_any,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rbrh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbrh_pkg::BYTE_W-1:0]    cfg_data
);

    localparam int AW = $clog2(HIST_BINS);

    logic                s_acc;
    logic                step;
    logic                inc;
    logic [AW-1:0]       inc_addr;
    rbrh_pkg::totals_t   totals;
    rbrh_pkg::hist_req_t req;
    logic                busy;
    logic                rd_pending;
    logic                res_valid;
    rbrh_pkg::result_t   res;
    rbrh_pkg::result_t   out_res;
    logic [1:0]          held;
    logic [2:0]          queued;
    logic                pop;

    // Results in flight or held; a pop this cycle frees a slot.
    always_comb begin
        pop     = m_valid && m_ready;
        queued  = 3'(held) + 3'(rd_pending);
        s_ready = !busy && (queued < (3'd2 + 3'(pop)));
        s_acc   = s_valid && s_ready;
        step    = s_acc && (s_op == rbrh_pkg::OP_BYTE);
        req.inc = inc;
        req.rd  = s_acc && (s_op == rbrh_pkg::OP_READ);
    end

    // Registers are always writable.
    assign cfg_ready = 1'b1;

    rbrh_run_tracker #(
        .HIST_BINS(HIST_BINS)
    ) u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step         (step),
        .data_byte    (s_data_byte),
        .segment_end  (s_segment_end),
        .byte_position(s_byte_position),
        .file_number  (s_file_number),
        .inc          (inc),
        .inc_addr     (inc_addr),
        .totals       (totals)
    );

    // Snapshot of the totals rides along with a read through the memory stage.
    rbrh_hist_mem #(
        .HIST_BINS(HIST_BINS)
    ) u_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .inc_addr  (inc_addr),
        .bin_select(s_bin_select),
        .totals    (totals),
        .busy      (busy),
        .rd_pending(rd_pending),
        .res_valid (res_valid),
        .res       (res)
    );

    rbrh_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_res   (res),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_res  (out_res),
        .held     (held)
    );

    always_comb begin
        m_bin_count      = out_res.bin_count;
        m_total_bytes    = out_res.tot.total_bytes;
        m_longest_length = out_res.tot.best_length;
        m_longest_start  = out_res.tot.best_start;
        m_longest_file   = out_res.tot.best_file;
        m_found_any      = out_res.tot.best_valid;
    end

    // Hold off input beats during the clearing pass.
    assert property (@(posedge aclk) disable iff (!aresetn) busy |-> !s_ready)
        else $error("input beat allowed during bin clearing");

    // Result buffer never drops an entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> ((held < 2'd2) || pop))
        else $error("result buffer overflow");

    // A read beat reaches the result stage in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) req.rd |=> res_valid)
        else $error("read beat lost in memory stage");

    // Longest run record never shrinks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (totals.best_length >= $past(totals.best_length)))
        else $error("longest run length decreased");

    // No recorded run means an empty record.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found_any) |-> (m_longest_length == '0))
        else $error("longest length set without a recorded run");

endmodule : repeated_byte_run_histogram

`default_nettype wire

[rtl/rbrh_run_tracker.sv]
// Run tracking, byte total, longest-run record and the filter registers.
// Depends on rbrh_pkg.
`default_nettype none

module rbrh_run_tracker #(
    parameter int HIST_BINS = rbrh_pkg::HIST_BINS_DEF,
    localparam int AW = $clog2(HIST_BINS)
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [rbrh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbrh_pkg::BYTE_W-1:0]    cfg_data,
    input  wire logic                           step,
    input  wire logic [rbrh_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic                           segment_end,
    input  wire logic [rbrh_pkg::POS_W-1:0]     byte_position,
    input  wire logic [rbrh_pkg::FILE_W-1:0]    file_number,
    output logic                                inc,
    output logic [AW-1:0]                       inc_addr,
    output rbrh_pkg::totals_t                   totals
);

    localparam logic [rbrh_pkg::LEN_W-1:0] TOP_BIN = rbrh_pkg::LEN_W'(HIST_BINS - 1);

    logic                          match_any_reg, match_any_next;
    logic [rbrh_pkg::BYTE_W-1:0]   match_byte_reg, match_byte_next;
    logic                          run_active_reg, run_active_next;
    logic [rbrh_pkg::BYTE_W-1:0]   run_value_reg, run_value_next;
    logic [rbrh_pkg::LEN_W-1:0]    run_length_reg, run_length_next;
    logic [rbrh_pkg::POS_W-1:0]    run_start_reg, run_start_next;
    logic [rbrh_pkg::FILE_W-1:0]   run_file_reg, run_file_next;
    rbrh_pkg::totals_t             tot_reg, tot_next;

    logic                          same;
    logic [rbrh_pkg::LEN_W-1:0]    len_inc;
    logic                          cand_act;
    logic                          cand_now;
    logic [rbrh_pkg::LEN_W-1:0]    cand_len;
    logic [rbrh_pkg::BYTE_W-1:0]   cand_val;
    logic [rbrh_pkg::POS_W-1:0]    cand_start;
    logic [rbrh_pkg::FILE_W-1:0]   cand_file;

    always_comb begin
        match_any_next  = match_any_reg;
        match_byte_next = match_byte_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                rbrh_pkg::REG_MATCH_ANY:  match_any_next  = cfg_data[0];
                rbrh_pkg::REG_MATCH_BYTE: match_byte_next = cfg_data;
                default: ;
            endcase
        end
    end

    // Pick the run that closes on this byte, if any. A differing byte closes
    // the old run; a segment end on a repeated byte closes the grown run.
    always_comb begin
        same    = run_active_reg && (data_byte == run_value_reg);
        len_inc = (run_length_reg == '1) ? run_length_reg
                                         : run_length_reg + rbrh_pkg::LEN_W'(1);
        cand_val   = run_value_reg;
        cand_start = run_start_reg;
        cand_file  = run_file_reg;
        if (same) begin
            cand_act = 1'b1;
            cand_len = len_inc;
            cand_now = segment_end;
        end else begin
            cand_act = run_active_reg;
            cand_len = run_length_reg;
            cand_now = 1'b1;
        end
        inc = step && cand_now && cand_act && (cand_len >= rbrh_pkg::MIN_RUN) &&
              (match_any_reg || (cand_val == match_byte_reg));
        inc_addr = (cand_len > TOP_BIN) ? AW'(HIST_BINS - 1) : cand_len[AW-1:0];
    end

    always_comb begin
        run_active_next = run_active_reg;
        run_value_next  = run_value_reg;
        run_length_next = run_length_reg;
        run_start_next  = run_start_reg;
        run_file_next   = run_file_reg;
        tot_next        = tot_reg;
        if (step) begin
            if (tot_reg.total_bytes != '1) begin
                tot_next.total_bytes = tot_reg.total_bytes + rbrh_pkg::TOTAL_W'(1);
            end
            if (same) begin
                run_length_next = len_inc;
            end else begin
                run_active_next = 1'b1;
                run_value_next  = data_byte;
                run_length_next = rbrh_pkg::LEN_W'(1);
                run_start_next  = byte_position;
                run_file_next   = file_number;
            end
            if (segment_end) begin
                run_active_next = 1'b0;
                run_length_next = '0;
            end
        end
        // record only a strictly longer run
        if (inc && (cand_len > tot_reg.best_length)) begin
            tot_next.best_length = cand_len;
            tot_next.best_start  = cand_start;
            tot_next.best_file   = cand_file;
            tot_next.best_valid  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_any_reg  <= 1'b1;
            match_byte_reg <= '0;
            run_active_reg <= 1'b0;
            run_value_reg  <= '0;
            run_length_reg <= '0;
            run_start_reg  <= '0;
            run_file_reg   <= '0;
            tot_reg        <= '0;
        end else begin
            match_any_reg  <= match_any_next;
            match_byte_reg <= match_byte_next;
            run_active_reg <= run_active_next;
            run_value_reg  <= run_value_next;
            run_length_reg <= run_length_next;
            run_start_reg  <= run_start_next;
            run_file_reg   <= run_file_next;
            tot_reg        <= tot_next;
        end
    end

    assign totals = tot_reg;

endmodule : rbrh_run_tracker

`default_nettype wire

[rtl/rbrh_hist_mem.sv]
// Histogram bin memory: clear pass, read-modify-write with forwarding,
// and bin reads for results. Depends on rbrh_pkg.
`default_nettype none

module rbrh_hist_mem #(
    parameter int HIST_BINS = rbrh_pkg::HIST_BINS_DEF,
    localparam int AW = $clog2(HIST_BINS)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire rbrh_pkg::hist_req_t          req,
    input  wire logic [AW-1:0]                inc_addr,
    input  wire logic [rbrh_pkg::BYTE_W-1:0]  bin_select,
    input  wire rbrh_pkg::totals_t            totals,
    output logic                              busy,
    output logic                              rd_pending,
    output logic                              res_valid,
    output rbrh_pkg::result_t                 res
);

    logic [rbrh_pkg::COUNT_W-1:0] mem [HIST_BINS];

    logic                         clearing_reg;
    logic [AW-1:0]                clr_addr_reg;

    logic                         b_inc_reg;
    logic                         b_rd_reg;
    logic [AW-1:0]                b_addr_reg;
    logic                         b_fwd_reg;
    logic [rbrh_pkg::COUNT_W-1:0] b_fwd_data_reg;
    logic                         b_range_reg;
    rbrh_pkg::totals_t            b_tot_reg;
    logic [rbrh_pkg::COUNT_W-1:0] rdata_reg;

    logic [31:0]                  sel_ext;
    logic                         sel_in_range;
    logic [AW-1:0]                a_addr;
    logic                         a_en;
    logic [rbrh_pkg::COUNT_W-1:0] cur;
    logic [rbrh_pkg::COUNT_W-1:0] wr_data;

    always_comb begin
        sel_ext      = 32'(bin_select);
        sel_in_range = sel_ext < 32'(HIST_BINS);
        a_addr       = req.inc ? inc_addr : sel_ext[AW-1:0];
        a_en         = req.inc || req.rd;
        // newest value of the bin in stage B
        cur          = b_fwd_reg ? b_fwd_data_reg : rdata_reg;
        wr_data      = (cur == '1) ? cur : cur + rbrh_pkg::COUNT_W'(1);
    end

    // single port pair: read in stage A, write back in stage B or clear
    always_ff @(posedge aclk) begin
        if (a_en) begin
            rdata_reg <= mem[a_addr];
        end
        if (clearing_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (b_inc_reg) begin
            mem[b_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            b_inc_reg    <= 1'b0;
            b_rd_reg     <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(HIST_BINS - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            b_inc_reg <= req.inc;
            b_rd_reg  <= req.rd;
        end
    end

    // forward the write-back that lands on the same edge as a new read
    always_ff @(posedge aclk) begin
        b_addr_reg     <= a_addr;
        b_fwd_reg      <= b_inc_reg && (b_addr_reg == a_addr);
        b_fwd_data_reg <= wr_data;
        b_range_reg    <= sel_in_range;
        b_tot_reg      <= totals;
    end

    always_comb begin
        res.bin_count = b_range_reg ? cur : '0;
        res.tot       = b_tot_reg;
    end

    assign busy       = clearing_reg;
    assign rd_pending = b_rd_reg;
    assign res_valid  = b_rd_reg;

endmodule : rbrh_hist_mem

`default_nettype wire

[rtl/rbrh_out_buf.sv]
// Two-entry result buffer: output register plus skid register.
// Depends on rbrh_pkg.
`default_nettype none

module rbrh_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire rbrh_pkg::result_t in_res,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rbrh_pkg::result_t      out_res,
    output logic [1:0]             held
);

    logic              head_valid_reg, head_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    rbrh_pkg::result_t head_reg, head_next;
    rbrh_pkg::result_t skid_reg, skid_next;
    logic              pop;

    always_comb begin
        pop             = head_valid_reg && out_ready;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                head_next       = skid_reg;
                skid_next       = in_res;
                skid_valid_next = in_valid;
            end else begin
                head_next       = in_res;
                head_valid_next = in_valid;
            end
        end else if (!head_valid_reg) begin
            head_next       = in_res;
            head_valid_next = in_valid;
        end else if (in_valid) begin
            skid_next       = in_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_valid = head_valid_reg;
    assign out_res   = head_reg;
    assign held      = 2'(head_valid_reg) + 2'(skid_valid_reg);

endmodule : rbrh_out_buf

`default_nettype wire
